[hw/rtl/piezo_hit_to_midi_note_macros.svh]
// Assertion macros shared by the piezo hit to MIDI note block.
`ifndef PIEZO_HIT_TO_MIDI_NOTE_MACROS_SVH
`define PIEZO_HIT_TO_MIDI_NOTE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define PHMN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define PHMN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PHMN_ASSERT_IMP(lbl, ante, cons)
`define PHMN_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/phmn_pkg.sv]
// Package with the constants, types and note ROM of the piezo hit to MIDI note block.
package phmn_pkg;

    // Field widths.
    localparam int MODE_W     = 2;
    localparam int CODE_W     = 12;
    localparam int MV_W       = 12;
    localparam int VEL_W      = 7;
    localparam int NOTE_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    // Capture window length in samples, not counting the triggering sample.
    localparam int WINDOW_SAMPLES = 400;
    localparam int WIN_CNT_W      = $clog2(WINDOW_SAMPLES + 1);

    // Note table.
    localparam int NOTE_COUNT = 17;
    localparam int NOTE_IDX_W = $clog2(NOTE_COUNT);

    // Code to millivolt conversion: mv = floor(code * MV_SCALE / 4095).
    localparam int MV_SCALE = 3300;
    localparam int PROD_W   = 24;

    // Rounding divider for the velocity map.
    localparam int NUM_W      = 21;
    localparam int DIVIDEND_W = 20;
    localparam int DIVISOR_W  = 13;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Input modes.
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PREV   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VEL    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL    = 8'd3;

    // Configuration reset values.
    localparam logic [MV_W-1:0]  RST_THRESHOLD  = 12'd90;
    localparam logic [MV_W-1:0]  RST_FULL_SCALE = 12'd2000;
    localparam logic [VEL_W-1:0] RST_MIN_VEL    = 7'd25;
    localparam logic [VEL_W-1:0] RST_MAX_VEL    = 7'd127;

    // MIDI sequence: note off (note on with zero velocity), then note on.
    localparam logic [BYTE_W-1:0] MIDI_NOTE_ON = 8'h90;
    localparam logic [BYTE_W-1:0] MIDI_VEL_OFF = 8'h00;
    localparam int                BYTE_IDX_W   = 3;
    localparam logic [BYTE_IDX_W-1:0] BYTE_STATUS_OFF = 3'd0;
    localparam logic [BYTE_IDX_W-1:0] BYTE_NOTE_OFF   = 3'd1;
    localparam logic [BYTE_IDX_W-1:0] BYTE_VEL_OFF    = 3'd2;
    localparam logic [BYTE_IDX_W-1:0] BYTE_STATUS_ON  = 3'd3;
    localparam logic [BYTE_IDX_W-1:0] BYTE_NOTE_ON    = 3'd4;
    localparam logic [BYTE_IDX_W-1:0] BYTE_VEL_ON     = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_in;
        logic eval;
        logic peak_prod;
        logic calc_mv;
        logic calc_num;
        logic div_init;
        logic div_step;
        logic vel_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic window_done;
        logic send_busy;
    } t_dp_status;

    // Drum note ROM; unused indexes fall back to the first entry.
    function automatic logic [NOTE_W-1:0] note_rom(input logic [NOTE_IDX_W-1:0] idx);
        logic [NOTE_W-1:0] note;
        case (idx)
            5'd0:    note = 7'd36;
            5'd1:    note = 7'd38;
            5'd2:    note = 7'd37;
            5'd3:    note = 7'd42;
            5'd4:    note = 7'd44;
            5'd5:    note = 7'd46;
            5'd6:    note = 7'd65;
            5'd7:    note = 7'd48;
            5'd8:    note = 7'd45;
            5'd9:    note = 7'd41;
            5'd10:   note = 7'd51;
            5'd11:   note = 7'd53;
            5'd12:   note = 7'd49;
            5'd13:   note = 7'd57;
            5'd14:   note = 7'd58;
            5'd15:   note = 7'd52;
            5'd16:   note = 7'd55;
            default: note = 7'd36;
        endcase
        return note;
    endfunction

endpackage

[hw/rtl/phmn_if.sv]
// Valid/ready channel interfaces for sample input, configuration writes and MIDI output.
interface phmn_in_if
    import phmn_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CODE_W-1:0] sample_code;

    modport source (output valid, output mode, output sample_code, input ready);
    modport sink   (input valid, input mode, input sample_code, output ready);
endinterface

interface phmn_cfg_if
    import phmn_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface phmn_out_if
    import phmn_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] midi_byte;
    logic              last_byte;

    modport source (output valid, output midi_byte, output last_byte, input ready);
    modport sink   (input valid, input midi_byte, input last_byte, output ready);
endinterface

[hw/rtl/piezo_hit_to_midi_note.sv]
// Top level of the piezo hit to MIDI note block: controller, datapath and channels.
//
//   Channel    Dir  Members                         Role
//   i_sample   in   valid ready mode sample_code    ADC samples and note buttons
//   i_cfg      in   valid ready index data          configuration register writes
//   o_midi     out  valid ready midi_byte last_byte six-byte MIDI note sequence
//
// Every input request is accepted in S_IDLE, forming code * 3300, then handled in
// S_EVAL, which converts to millivolts and updates the capture or note state.
// A window-closing sample then runs the velocity map (S_PEAK, S_MV, S_NUM, S_INIT,
// the one-bit-per-cycle rounding divider in S_DIV, S_FIN) before the next request.
// The six MIDI bytes leave one per cycle from their own sender while o_midi.ready is
// high; requests are accepted while they drain; a window end waits for the sender.
// Synchronous active-low reset restores the register defaults and note index 0.
// Configuration writes are always accepted and update the registers directly, so a request in progress may read them.

module piezo_hit_to_midi_note
    import phmn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    phmn_in_if.sink    i_sample,
    phmn_cfg_if.sink   i_cfg,
    phmn_out_if.source o_midi
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // The controller owns the input handshake; the datapath only sees the payload.
    phmn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    assign i_sample.ready = w_in_ready;

    // Configuration, capture state, the divider and the byte sender live here.
    phmn_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_mode        (i_sample.mode),
        .i_sample_code (i_sample.sample_code),
        .i_cfg         (i_cfg),
        .o_midi        (o_midi)
    );

endmodule

[hw/rtl/phmn_ctrl.sv]
// Controller state machine that sequences sample handling and the velocity computation.
`include "piezo_hit_to_midi_note_macros.svh"

module phmn_ctrl
    import phmn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PEAK,
        S_MV,
        S_NUM,
        S_INIT,
        S_DIV,
        S_FIN
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [DIV_CNT_W-1:0]  n_div_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept_in = i_in_valid && o_in_ready;
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.peak_prod = (r_state == S_PEAK);
        o_cmd.calc_mv   = (r_state == S_MV);
        o_cmd.calc_num  = (r_state == S_NUM);
        o_cmd.div_init  = (r_state == S_INIT);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.vel_load  = (r_state == S_FIN) && !i_status.send_busy;
    end

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_status.window_done ? S_PEAK : S_IDLE;
            end
            S_PEAK: n_state = S_MV;
            S_MV:   n_state = S_NUM;
            S_NUM:  n_state = S_INIT;
            S_INIT: begin
                n_state   = S_DIV;
                n_div_cnt = '0;
            end
            S_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            S_FIN: begin
                if (!i_status.send_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    `PHMN_ASSERT_NXT(a_accept_to_eval, i_in_valid && o_in_ready, r_state == S_EVAL)
    `PHMN_ASSERT_NXT(a_window_end_to_vel, (r_state == S_EVAL) && i_status.window_done, !o_in_ready && (r_state == S_PEAK))
    `PHMN_ASSERT_IMP(a_div_cnt_bound, r_state == S_DIV, r_div_cnt < DIV_CNT_W'(DIV_STEPS))

endmodule

[hw/rtl/phmn_dpath.sv]
// Datapath with configuration, capture state, velocity divider and MIDI byte sender.
`include "piezo_hit_to_midi_note_macros.svh"

module phmn_dpath
    import phmn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [CODE_W-1:0] i_sample_code,
    phmn_cfg_if.sink          i_cfg,
    phmn_out_if.source        o_midi
);

    // Configuration registers.
    logic [MV_W-1:0]  r_thr;
    logic [MV_W-1:0]  r_fs;
    logic [VEL_W-1:0] r_vmin;
    logic [VEL_W-1:0] r_vmax;

    // Captured request and capture state.
    logic [MODE_W-1:0]     r_mode;
    logic [CODE_W-1:0]     r_code;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_capt;
    logic [WIN_CNT_W-1:0]  r_count;
    logic [CODE_W-1:0]     r_peak;
    logic [NOTE_IDX_W-1:0] r_note_idx;

    // Velocity map.
    logic signed [MV_W:0]      r_mvdiff;
    logic signed [MV_W:0]      r_den;
    logic signed [VEL_W:0]     r_span;
    logic signed [NUM_W-1:0]   r_num;
    logic                      r_neg;
    logic [DIVIDEND_W-1:0]     r_dvd;
    logic [DIVISOR_W-1:0]      r_dsr;
    logic [DIVISOR_W-1:0]      r_rem;

    // Byte sender.
    logic                  r_busy;
    logic [BYTE_IDX_W-1:0] r_bidx;
    logic [NOTE_W-1:0]     r_note;
    logic [VEL_W-1:0]      r_vel;

    logic [PROD_W:0]        w_mv_sum;
    logic [MV_W-1:0]        w_mv;
    logic                   w_last_sample;
    logic [NUM_W-1:0]       w_num_abs;
    logic [DIVISOR_W:0]     w_rem_sh;
    logic [DIVISOR_W:0]     w_rem_sub;
    logic                   w_qbit;
    logic                   w_den_pos;
    logic signed [21:0]     w_qs;
    logic signed [21:0]     w_lo;
    logic signed [21:0]     w_hi;
    logic signed [21:0]     w_sum;
    logic signed [21:0]     w_vclamp;
    logic [VEL_W-1:0]       w_vel;

    assign i_cfg.ready = 1'b1;

    // Division by 4095 as a shift-and-add, exact for products below 4095 * 4096.
    assign w_mv_sum = {1'b0, r_prod} + (PROD_W + 1)'(r_prod >> CODE_W) + 1'b1;
    assign w_mv     = w_mv_sum[PROD_W-1:CODE_W];

    assign w_last_sample        = r_capt && (r_count == WIN_CNT_W'(WINDOW_SAMPLES - 1));
    assign o_status.window_done = (r_mode == MODE_SAMPLE) && w_last_sample;
    assign o_status.send_busy   = r_busy;

    assign w_num_abs = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    // One restoring divider step per cycle; quotient bits shift into the dividend.
    assign w_rem_sh  = {r_rem, r_dvd[DIVIDEND_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dsr};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_dsr});

    assign w_den_pos = !r_den[MV_W] && (r_den != '0);

    always_comb begin
        w_qs = r_neg ? -$signed({2'b00, r_dvd}) : $signed({2'b00, r_dvd});
        w_lo = $signed({15'd0, r_vmin});
        w_hi = $signed({15'd0, r_vmax});
        w_sum = w_den_pos ? (w_lo + w_qs) : w_hi;
        w_vclamp = (w_sum > w_hi) ? w_hi : w_sum;
        if (w_vclamp < w_lo) begin
            w_vclamp = w_lo;
        end
        w_vel = w_vclamp[VEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= RST_THRESHOLD;
            r_fs   <= RST_FULL_SCALE;
            r_vmin <= RST_MIN_VEL;
            r_vmax <= RST_MAX_VEL;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_THRESHOLD:  r_thr  <= i_cfg.data;
                CFG_FULL_SCALE: r_fs   <= i_cfg.data;
                CFG_MIN_VEL:    r_vmin <= i_cfg.data[VEL_W-1:0];
                CFG_MAX_VEL:    r_vmax <= i_cfg.data[VEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture and the shared code-times-scale product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_in) begin
            r_mode <= i_mode;
            r_code <= i_sample_code;
            r_prod <= PROD_W'(i_sample_code) * PROD_W'(MV_SCALE);
        end else if (i_cmd.peak_prod) begin
            r_prod <= PROD_W'(r_peak) * PROD_W'(MV_SCALE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capt     <= 1'b0;
            r_count    <= '0;
            r_peak     <= '0;
            r_note_idx <= '0;
        end else if (i_cmd.eval) begin
            case (r_mode)
                MODE_SAMPLE: begin
                    if (!r_capt) begin
                        if (w_mv > r_thr) begin
                            r_capt  <= 1'b1;
                            r_count <= '0;
                            r_peak  <= '0;
                        end
                    end else begin
                        if (r_code > r_peak) begin
                            r_peak <= r_code;
                        end
                        if (w_last_sample) begin
                            r_capt  <= 1'b0;
                            r_count <= '0;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                MODE_NEXT: begin
                    if (!r_capt) begin
                        r_note_idx <= (r_note_idx == NOTE_IDX_W'(NOTE_COUNT - 1)) ?
                                      '0 : r_note_idx + 1'b1;
                    end
                end
                MODE_PREV: begin
                    if (!r_capt) begin
                        r_note_idx <= (r_note_idx == '0) ?
                                      NOTE_IDX_W'(NOTE_COUNT - 1) : r_note_idx - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_mv) begin
            r_mvdiff <= $signed({1'b0, w_mv}) - $signed({1'b0, r_thr});
            r_den    <= $signed({1'b0, r_fs}) - $signed({1'b0, r_thr});
            r_span   <= $signed({1'b0, r_vmax}) - $signed({1'b0, r_vmin});
        end
        if (i_cmd.calc_num) begin
            r_num <= NUM_W'(r_mvdiff) * NUM_W'(r_span);
        end
        if (i_cmd.div_init) begin
            // Rounded quotient: floor((2|num| + den) / (2 den)).
            r_dvd <= {w_num_abs[DIVIDEND_W-2:0], 1'b0} + DIVIDEND_W'(r_den[MV_W-1:0]);
            r_dsr <= {r_den[MV_W-1:0], 1'b0};
            r_rem <= '0;
            r_neg <= r_num[NUM_W-1];
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_rem_sub[DIVISOR_W-1:0] : w_rem_sh[DIVISOR_W-1:0];
            r_dvd <= {r_dvd[DIVIDEND_W-2:0], w_qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bidx <= '0;
        end else if (i_cmd.vel_load) begin
            r_busy <= 1'b1;
            r_bidx <= BYTE_STATUS_OFF;
        end else if (o_midi.valid && o_midi.ready) begin
            if (r_bidx == BYTE_VEL_ON) begin
                r_busy <= 1'b0;
                r_bidx <= BYTE_STATUS_OFF;
            end else begin
                r_bidx <= r_bidx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vel_load) begin
            r_note <= note_rom(r_note_idx);
            r_vel  <= w_vel;
        end
    end

    assign o_midi.valid     = r_busy;
    assign o_midi.last_byte = (r_bidx == BYTE_VEL_ON);

    always_comb begin
        case (r_bidx) inside
            BYTE_STATUS_OFF, BYTE_STATUS_ON: o_midi.midi_byte = MIDI_NOTE_ON;
            BYTE_NOTE_OFF, BYTE_NOTE_ON:     o_midi.midi_byte = {1'b0, r_note};
            BYTE_VEL_OFF:                    o_midi.midi_byte = MIDI_VEL_OFF;
            default:                         o_midi.midi_byte = {1'b0, r_vel};
        endcase
    end

    `PHMN_ASSERT_NXT(a_load_starts_seq, i_cmd.vel_load, r_busy && (r_bidx == BYTE_STATUS_OFF))
    `PHMN_ASSERT_IMP(a_bidx_range, r_busy, r_bidx <= BYTE_VEL_ON)

endmodule
